// ----- rtl/ppm_pkg.sv -----
// shared types and constants for the pulse period meter
package ppm_pkg;

    localparam int TIME_W  = 32;
    localparam int DEB_W   = 20;
    localparam int TALLY_W = 16;
    localparam int CHAN_W  = 2;

    localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 20'd5000;

    typedef enum logic {
        CMD_EDGE  = 1'b0,
        CMD_QUERY = 1'b1
    } ppm_cmd_t;

    // edge update request into one channel
    typedef struct packed {
        logic              edge_hit;
        logic [TIME_W-1:0] time_us;
    } ppm_chan_req_t;

    // stored state of one channel
    typedef struct packed {
        logic [TIME_W-1:0]  last_edge;
        logic               base_valid;
        logic [TIME_W-1:0]  last_period;
        logic [TALLY_W-1:0] tally;
    } ppm_chan_state_t;

endpackage

// ----- rtl/ppm_channel.sv -----
// state and edge update logic for one measurement channel
module ppm_channel
    import ppm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ppm_chan_req_t         req,
    input  logic [DEB_W-1:0]      debounce,
    output ppm_chan_state_t       state
);

    ppm_chan_state_t state_reg;
    ppm_chan_state_t state_next;
    logic [TIME_W-1:0] interval;

    assign interval = req.time_us - state_reg.last_edge;

    always_comb
    begin
        state_next = state_reg;
        if (req.edge_hit)
        begin
            if (!state_reg.base_valid || (req.time_us <= state_reg.last_edge))
            begin
                // no baseline yet or time did not advance: rebase only
                state_next.last_edge  = req.time_us;
                state_next.base_valid = 1'b1;
            end
            else if (interval >= {{(TIME_W-DEB_W){1'b0}}, debounce})
            begin
                state_next.last_period = interval;
                state_next.tally       = state_reg.tally + TALLY_W'(1);
                state_next.last_edge   = req.time_us;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

// ----- rtl/multi_channel_pulse_period_meter_top.sv -----
// top level of the multi-channel pulse period meter
// a query is held in the input register stage, then its result in the result register
// throughput: one request per cycle unless stalled; edges absorbed even when output stalls
// per-channel state is read and rewritten in a single pass, so back-to-back
// requests on the same channel see each other's updates
// reset: asynchronous, clears all channel state, no clearing pass; debounce returns to 5000
module multi_channel_pulse_period_meter_top
    import ppm_pkg::*;
#(
    parameter int CHANNELS = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    // debounce configuration
    input  logic                cfg_write,
    input  logic [DEB_W-1:0]    cfg_data,
    // request channel
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                command,
    input  logic [CHAN_W-1:0]   channel,
    input  logic [TIME_W-1:0]   time_us,
    // result channel
    output logic                out_valid,
    input  logic                out_stall,
    output logic [TIME_W-1:0]   period_us,
    output logic [TALLY_W-1:0]  valid_pulses
);

    // debounce register
    logic [DEB_W-1:0] debounce_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
        end
        else if (cfg_write)
        begin
            debounce_reg <= cfg_data;
        end
    end

    // input register stage
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic              s1_cmd_reg;
    logic [CHAN_W-1:0] s1_chan_reg;
    logic [TIME_W-1:0] s1_time_reg;

    logic out_valid_reg;
    logic out_valid_next;
    logic [TIME_W-1:0]  period_reg;
    logic [TIME_W-1:0]  period_next;
    logic [TALLY_W-1:0] pulses_reg;
    logic [TALLY_W-1:0] pulses_next;

    logic out_free;
    logic s1_is_query;
    logic s1_process;
    logic in_take;

    // output register can load when empty or being drained
    assign out_free    = !(out_valid_reg && out_stall);
    assign s1_is_query = (s1_cmd_reg == CMD_QUERY);
    // an edge produces no result, so it never waits for the output
    assign s1_process  = s1_valid_reg && (!s1_is_query || out_free);
    assign in_stall    = s1_valid_reg && !s1_process;
    assign in_take     = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_process)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_cmd_reg  <= command;
            s1_chan_reg <= channel;
            s1_time_reg <= time_us;
        end
    end

    // channel bank
    ppm_chan_req_t   chan_req   [CHANNELS];
    ppm_chan_state_t chan_state [CHANNELS];

    for (genvar gi = 0; gi < CHANNELS; gi++)
    begin : g_chan
        always_comb
        begin
            chan_req[gi].edge_hit = s1_process && !s1_is_query
                                    && (32'(s1_chan_reg) == gi);
            chan_req[gi].time_us  = s1_time_reg;
        end

        ppm_channel u_channel (
            .clk      (clk),
            .rst_n    (rst_n),
            .req      (chan_req[gi]),
            .debounce (debounce_reg),
            .state    (chan_state[gi])
        );
    end

    // pick the addressed channel; out-of-range channels read as absent
    ppm_chan_state_t sel_state;
    logic            sel_hit;

    always_comb
    begin
        sel_state = '0;
        sel_hit   = 1'b0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (32'(s1_chan_reg) == i)
            begin
                sel_state = chan_state[i];
                sel_hit   = 1'b1;
            end
        end
    end

    // staleness: elapsed time against interval plus half, in 33 bits
    logic [TIME_W-1:0] since;
    logic [TIME_W:0]   limit;
    logic              stale;

    assign since = s1_time_reg - sel_state.last_edge;
    assign limit = {1'b0, sel_state.last_period}
                   + {2'b00, sel_state.last_period[TIME_W-1:1]};
    assign stale = ({1'b0, since} > limit);

    always_comb
    begin
        period_next = '0;
        pulses_next = '0;
        if (sel_hit)
        begin
            pulses_next = sel_state.tally;
            if ((sel_state.last_period != '0) && !stale)
            begin
                period_next = sel_state.last_period;
            end
        end
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = s1_process && s1_is_query;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_process && s1_is_query)
        begin
            period_reg <= period_next;
            pulses_reg <= pulses_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign period_us    = period_reg;
    assign valid_pulses = pulses_reg;

endmodule
